// ----- rtl/hfi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hfi_pkg;

    // stream and position widths
    localparam int BYTE_W = 8;
    localparam int POS_W  = 48;
    localparam int LEN_W  = 24;
    localparam int NUM_W  = 32;
    localparam int DUR_W  = 32;
    localparam int TS_W   = 64;
    localparam int HIST_W = 24;

    // nal header decode
    localparam int NAL_W = 5;
    localparam logic [NAL_W-1:0] NAL_SLICE_FIRST = 5'd1;
    localparam logic [NAL_W-1:0] NAL_SLICE_LAST  = 5'd4;
    localparam logic [NAL_W-1:0] NAL_IDR         = 5'd5;

    // frame type codes
    localparam logic TYPE_INTRA     = 1'b0;
    localparam logic TYPE_PREDICTED = 1'b1;

    // start code tail and saturation limit
    localparam logic [BYTE_W-1:0] SC_LAST_BYTE = 8'h01;
    localparam logic [LEN_W-1:0]  LEN_MAX      = {LEN_W{1'b1}};
    localparam logic [POS_W-1:0]  SC_LEAD      = 48'd3;
    localparam logic [1:0]        SEEN_FULL    = 2'd3;

    // event queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // one classified nal header
    typedef struct packed {
        logic             is_slice;
        logic             slice_type;
        logic [POS_W-1:0] position;
    } t_event;

    // queue status seen by the front
    typedef struct packed {
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

// ----- rtl/hfi_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hfi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface hfi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_number;
    logic [63:0] timestamp;
    logic        frame_type;
    logic [47:0] frame_position;
    logic [23:0] frame_length;

    modport source (output valid, output frame_number, output timestamp, output frame_type,
                    output frame_position, output frame_length, input ready);
    modport sink (input valid, input frame_number, input timestamp, input frame_type,
                  input frame_position, input frame_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/hfi_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hfi_front
    import hfi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    output logic                   o_ready,
    input  wire t_q_status         i_q_status,
    output logic                   o_push,
    output t_event                 o_push_data
);

    logic [HIST_W-1:0] r_history, n_history;
    logic [POS_W-1:0]  r_offset, n_offset;
    logic [1:0]        r_bytes_seen, n_bytes_seen;
    logic              r_header_pending, n_header_pending;
    logic [POS_W-1:0]  r_sc_pos, n_sc_pos;

    logic              accept;
    logic              start_found;
    logic [NAL_W-1:0]  nal;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign nal     = i_data_byte[NAL_W-1:0];

    // classify the header byte that follows a start code
    always_comb begin
        o_push_data.position   = r_sc_pos;
        o_push_data.is_slice   = 1'b0;
        o_push_data.slice_type = TYPE_INTRA;
        unique case (nal) inside
            [NAL_SLICE_FIRST:NAL_SLICE_LAST]: begin
                o_push_data.is_slice   = 1'b1;
                o_push_data.slice_type = TYPE_PREDICTED;
            end
            NAL_IDR: begin
                o_push_data.is_slice   = 1'b1;
                o_push_data.slice_type = TYPE_INTRA;
            end
            default: begin
                o_push_data.is_slice   = 1'b0;
                o_push_data.slice_type = TYPE_INTRA;
            end
        endcase
    end

    assign o_push = accept && r_header_pending;

    // start code search over the byte history
    assign start_found = (r_bytes_seen == SEEN_FULL) && (r_history == '0)
                      && (i_data_byte == SC_LAST_BYTE);

    always_comb begin
        n_history        = r_history;
        n_offset         = r_offset;
        n_bytes_seen     = r_bytes_seen;
        n_header_pending = r_header_pending;
        n_sc_pos         = r_sc_pos;
        if (accept) begin
            n_history        = {r_history[HIST_W-BYTE_W-1:0], i_data_byte};
            n_offset         = r_offset + POS_W'(1);
            n_header_pending = start_found;
            if (r_bytes_seen != SEEN_FULL) begin
                n_bytes_seen = r_bytes_seen + 2'd1;
            end
            if (start_found) begin
                n_sc_pos = r_offset - SC_LEAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history        <= '0;
            r_offset         <= '0;
            r_bytes_seen     <= '0;
            r_header_pending <= 1'b0;
        end else begin
            r_history        <= n_history;
            r_offset         <= n_offset;
            r_bytes_seen     <= n_bytes_seen;
            r_header_pending <= n_header_pending;
        end
    end

    // start code position is payload
    always_ff @(posedge i_clk) begin
        r_sc_pos <= n_sc_pos;
    end

    // a header can only be pending once three bytes have been seen
    a_pending_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_header_pending |-> r_bytes_seen == SEEN_FULL)
        else $error("header pending before history filled");

    // a detected start code always arms the header on the next byte
    a_start_arms_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && start_found |=> r_header_pending)
        else $error("start code did not arm header");

endmodule

`default_nettype wire

// ----- rtl/hfi_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hfi_queue
    import hfi_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_event    i_push_data,
    output t_q_status      o_status,
    input  wire logic      i_pop,
    output logic           o_valid,
    output t_event         o_data
);

    t_event          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]   r_count, n_count;
    logic            do_pop;

    assign o_status.full = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid       = (r_count != '0);
    assign o_data        = r_mem[r_rd_ptr];
    assign do_pop        = i_pop && o_valid;

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + Q_AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + Q_AW'(1);
        end
        if (i_push && !do_pop) begin
            n_count = r_count + (Q_AW+1)'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // fill level stays within the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("event queue overflow");

endmodule

`default_nettype wire

// ----- rtl/hfi_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hfi_back
    import hfi_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [DUR_W-1:0] i_frame_duration,
    input  wire logic             i_ev_valid,
    input  wire t_event           i_ev,
    output logic                  o_ev_pop,
    hfi_out_if.source             o_out
);

    // frame tracking state
    logic [POS_W-1:0] r_open_pos, n_open_pos;
    logic             r_open_valid, n_open_valid;
    logic             r_open_type, n_open_type;
    logic             r_prev_param, n_prev_param;
    logic [NUM_W-1:0] r_fc, n_fc;

    // record stage ahead of the multiply
    logic             r_s1_valid, n_s1_valid;
    logic [NUM_W-1:0] r_s1_number;
    logic             r_s1_type;
    logic [POS_W-1:0] r_s1_pos;
    logic [LEN_W-1:0] r_s1_len;

    // output register
    logic             r_o_valid;
    logic [NUM_W-1:0] r_o_number;
    logic [TS_W-1:0]  r_o_ts;
    logic             r_o_type;
    logic [POS_W-1:0] r_o_pos;
    logic [LEN_W-1:0] r_o_len;

    logic             out_move;
    logic             s1_free;
    logic             boundary;
    logic             new_type;
    logic             emit;
    logic [POS_W-1:0] diff;
    logic [LEN_W-1:0] len_sat;

    assign out_move = !r_o_valid || o_out.ready;
    assign s1_free  = !r_s1_valid || out_move;
    assign o_ev_pop = i_ev_valid && s1_free;

    // saturated frame length
    assign diff    = i_ev.position - r_open_pos;
    assign len_sat = (diff[POS_W-1:LEN_W] != '0) ? LEN_MAX : diff[LEN_W-1:0];

    // frame boundary decisions per nal unit
    always_comb begin
        n_open_pos   = r_open_pos;
        n_open_valid = r_open_valid;
        n_open_type  = r_open_type;
        n_prev_param = r_prev_param;
        n_fc         = r_fc;
        boundary     = 1'b0;
        new_type     = TYPE_INTRA;
        if (o_ev_pop) begin
            if (i_ev.is_slice) begin
                n_fc = r_fc + NUM_W'(1);
                if (r_prev_param) begin
                    n_open_type  = i_ev.slice_type;
                    n_prev_param = 1'b0;
                end else begin
                    boundary = 1'b1;
                    new_type = i_ev.slice_type;
                end
            end else if (!r_prev_param) begin
                boundary     = 1'b1;
                n_prev_param = 1'b1;
                new_type     = TYPE_INTRA;
            end
            if (boundary) begin
                n_open_pos   = i_ev.position;
                n_open_type  = new_type;
                n_open_valid = 1'b1;
            end
        end
    end

    assign emit = boundary && r_open_valid;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (s1_free) begin
            n_s1_valid = emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_valid <= 1'b0;
            r_open_type  <= TYPE_INTRA;
            r_prev_param <= 1'b0;
            r_fc         <= '0;
            r_s1_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_open_valid <= n_open_valid;
            r_open_type  <= n_open_type;
            r_prev_param <= n_prev_param;
            r_fc         <= n_fc;
            r_s1_valid   <= n_s1_valid;
            if (out_move) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    // record payload capture
    always_ff @(posedge i_clk) begin
        r_open_pos <= n_open_pos;
        if (s1_free && emit) begin
            r_s1_number <= n_fc;
            r_s1_type   <= r_open_type;
            r_s1_pos    <= r_open_pos;
            r_s1_len    <= len_sat;
        end
    end

    // timestamp multiply into the output register
    always_ff @(posedge i_clk) begin
        if (out_move && r_s1_valid) begin
            r_o_number <= r_s1_number;
            r_o_ts     <= TS_W'(r_s1_number) * TS_W'(i_frame_duration);
            r_o_type   <= r_s1_type;
            r_o_pos    <= r_s1_pos;
            r_o_len    <= r_s1_len;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.frame_number   = r_o_number;
    assign o_out.timestamp      = r_o_ts;
    assign o_out.frame_type     = r_o_type;
    assign o_out.frame_position = r_o_pos;
    assign o_out.frame_length   = r_o_len;

    // only slice units advance the frame counter
    a_count_on_slice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_pop && i_ev.is_slice |=> r_fc == $past(r_fc) + NUM_W'(1))
        else $error("frame counter missed a slice");

    // a record never leaves without an open frame behind it
    a_emit_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s1_valid) |-> $past(r_open_valid))
        else $error("record emitted with no open frame");

endmodule

`default_nettype wire

// ----- rtl/h264_frame_indexer_core.sv -----
// a record passes the event queue, the record stage and the output register after its boundary header beat
// throughput: one stream byte per cycle while the event queue is not full,
// bounded by the front byte compare and history update; the four-entry event queue
// and output register let the front keep taking beats while a record waits downstream
// reset: synchronous active-low i_rst_n clears search, frame state and duration to zero
`timescale 1ns / 1ps
`default_nettype none

module h264_frame_indexer_core
    import hfi_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    hfi_in_if.sink                i_in,
    hfi_out_if.source             o_out,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [DUR_W-1:0] i_cfg_wr_data
);

    logic [DUR_W-1:0] r_frame_duration;
    t_q_status        q_status;
    logic             q_push;
    t_event           q_push_data;
    logic             q_pop;
    logic             q_valid;
    t_event           q_data;

    // frame duration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_duration <= '0;
        end else if (i_cfg_wr_en) begin
            r_frame_duration <= i_cfg_wr_data;
        end
    end

    // byte scan and header classification
    hfi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_data_byte (i_in.data_byte),
        .o_ready     (i_in.ready),
        .i_q_status  (q_status),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // decoupling queue
    hfi_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_status    (q_status),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    // frame tracking and record output
    hfi_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_frame_duration (r_frame_duration),
        .i_ev_valid       (q_valid),
        .i_ev             (q_data),
        .o_ev_pop         (q_pop),
        .o_out            (o_out)
    );

endmodule

`default_nettype wire

// ----- verif/tb_h264_frame_indexer_core.sv -----
`timescale 1ns / 1ps

module tb_h264_frame_indexer_core;
    import hfi_pkg::*;

    // one index record as it leaves the block
    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic [TS_W-1:0]  stamp;
        logic             ftype;
        logic [POS_W-1:0] position;
        logic [LEN_W-1:0] length;
    } t_frame_rec;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_wr_en;
    logic [DUR_W-1:0] cfg_wr_data;

    hfi_in_if  in_if ();
    hfi_out_if out_if ();

    h264_frame_indexer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // records still owed by the block, oldest first
    t_frame_rec pending_index_q [$];
    int         n_errors    = 0;
    int         bytes_sent  = 0;
    bit         tx_no_idle  = 1'b0;
    bit         rx_no_stall = 1'b0;
    int         rx_wait     = 0;

    // mirrored parser and frame state
    logic [HIST_W-1:0] sc_history    = '0;
    logic [POS_W-1:0]  stream_offset = '0;
    bit                hdr_next      = 1'b0;
    logic [POS_W-1:0]  sc_position   = '0;
    logic [POS_W-1:0]  open_position = '0;
    bit                frame_open    = 1'b0;
    logic              open_type     = TYPE_INTRA;
    bit                in_param_run  = 1'b0;
    logic [NUM_W-1:0]  slice_count   = '0;
    logic [1:0]        bytes_warm    = '0;
    logic [DUR_W-1:0]  frame_ticks   = '0;

    // advance the mirrored parser by one accepted byte, queue any record it closes
    task automatic index_byte(input logic [BYTE_W-1:0] b);
        logic [NAL_W-1:0] nal;
        logic             slice_type;
        logic             new_type;
        bit               boundary;
        logic [POS_W-1:0] span;
        t_frame_rec       rec;
        boundary = 1'b0;
        new_type = TYPE_INTRA;
        if (hdr_next) begin
            hdr_next = 1'b0;
            nal = b[NAL_W-1:0];
            if (nal >= NAL_SLICE_FIRST && nal <= NAL_IDR) begin
                slice_type = (nal == NAL_IDR) ? TYPE_INTRA : TYPE_PREDICTED;
                if (in_param_run) begin
                    open_type    = slice_type;
                    in_param_run = 1'b0;
                end else begin
                    new_type = slice_type;
                    boundary = 1'b1;
                end
                slice_count = slice_count + 1'b1;
            end else if (!in_param_run) begin
                boundary     = 1'b1;
                in_param_run = 1'b1;
                new_type     = TYPE_INTRA;
            end
            if (boundary) begin
                if (frame_open) begin
                    span         = sc_position - open_position;
                    rec.number   = slice_count;
                    rec.stamp    = TS_W'(slice_count) * TS_W'(frame_ticks);
                    rec.ftype    = open_type;
                    rec.position = open_position;
                    rec.length   = (span > POS_W'(LEN_MAX)) ? LEN_MAX : span[LEN_W-1:0];
                    pending_index_q.push_back(rec);
                end
                open_position = sc_position;
                open_type     = new_type;
                frame_open    = 1'b1;
            end
        end
        // start code ends on this byte, header follows
        if (bytes_warm == SEEN_FULL && sc_history == '0 && b == SC_LAST_BYTE) begin
            hdr_next    = 1'b1;
            sc_position = stream_offset - SC_LEAD;
        end
        sc_history    = {sc_history[HIST_W-BYTE_W-1:0], b};
        stream_offset = stream_offset + 1'b1;
        if (bytes_warm != SEEN_FULL)
            bytes_warm = bytes_warm + 1'b1;
    endtask

    // push one stream byte through the input handshake
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        index_byte(b);
        bytes_sent++;
    endtask

    // drop valid, let the block drain, then load a new frame duration
    task automatic set_duration(input logic [DUR_W-1:0] ticks);
        in_if.valid <= 1'b0;
        while (pending_index_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        frame_ticks = ticks;
    endtask

    // one nal unit: start code, header, payload
    task automatic send_unit(input bit zero_rich);
        logic [NAL_W-1:0]  nal;
        logic [BYTE_W-1:0] hdr;
        int                len;
        int                pick;
        if ($urandom_range(0, 9) < 6) begin
            nal = NAL_W'($urandom_range(NAL_SLICE_FIRST, NAL_IDR));
        end else begin
            do nal = NAL_W'($urandom_range(0, 31));
            while (nal >= NAL_SLICE_FIRST && nal <= NAL_IDR);
        end
        hdr = {3'($urandom_range(0, 7)), nal};
        if ($urandom_range(0, 3) == 0)
            send_byte(8'h00);
        repeat (3) send_byte(8'h00);
        send_byte(SC_LAST_BYTE);
        send_byte(hdr);
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 5);
            if (zero_rich && pick < 2)
                send_byte(8'h00);
            else if (zero_rich && pick == 2)
                send_byte(SC_LAST_BYTE);
            else
                send_byte(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // units with random content, mixed with broken codes and stray bytes
    task automatic run_phase(input int n_bytes, input int noise_pct, input bit zero_rich);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes) begin
            if ($urandom_range(0, 7) == 0) tx_no_idle = !tx_no_idle;
            if ($urandom_range(0, 7) == 0) rx_no_stall = !rx_no_stall;
            if ($urandom_range(0, 99) >= noise_pct) begin
                send_unit(zero_rich);
            end else begin
                case ($urandom_range(0, 3))
                    0: send_byte(BYTE_W'($urandom_range(0, 255)));
                    1: begin
                        // three-byte code, only counts after a zero
                        send_byte(8'h00);
                        send_byte(8'h00);
                        send_byte(SC_LAST_BYTE);
                        send_byte(BYTE_W'($urandom_range(0, 255)));
                    end
                    2: begin
                        repeat (3) send_byte(8'h00);
                        send_byte(8'h02);
                    end
                    default: repeat ($urandom_range(1, 6)) send_byte(8'h00);
                endcase
            end
        end
    endtask

    // stream start, parameter run, overlapping codes, header opening a code
    task automatic test_directed_stream();
        logic [BYTE_W-1:0] seq [$];
        seq = '{8'h00, 8'h01,
                8'h00, 8'h00, 8'h00, 8'h01, 8'h67,
                8'h00, 8'h00, 8'h00, 8'h01, 8'hE8,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h88,
                8'h00, 8'h00, 8'h00, 8'h01, 8'h41,
                8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
                8'h00, 8'h00, 8'h01, 8'hFF,
                8'h00, 8'h00, 8'h00, 8'h01, 8'h25};
        set_duration('1);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_clean_units();
        set_duration('0);
        run_phase(300, 5, 1'b0);
    endtask

    task automatic test_back_to_back();
        set_duration(32'd1);
        tx_no_idle  = 1'b1;
        rx_no_stall = 1'b1;
        run_phase(200, 10, 1'b0);
    endtask

    task automatic test_noisy_stream();
        set_duration($urandom);
        run_phase(250, 40, 1'b1);
    endtask

    task automatic test_mixed_stream();
        set_duration($urandom);
        run_phase(250, 15, 1'b0);
    endtask

    // output side may stall after each beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                rx_wait = rx_no_stall ? 0 : $urandom_range(0, 5);
                out_if.ready <= (rx_wait == 0);
            end else if (rx_wait != 0) begin
                rx_wait = rx_wait - 1;
                out_if.ready <= (rx_wait == 0);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // compare each record beat against the oldest owed record
    always @(posedge i_clk) begin
        t_frame_rec want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_index_q.size() == 0) begin
                $error("unexpected record: frame_number %0d position %0d",
                       out_if.frame_number, out_if.frame_position);
                n_errors++;
            end else begin
                want = pending_index_q.pop_front();
                if (out_if.frame_number !== want.number) begin
                    $error("frame_number: expected %0d, got %0d", want.number, out_if.frame_number);
                    n_errors++;
                end
                if (out_if.timestamp !== want.stamp) begin
                    $error("timestamp: expected %0d, got %0d", want.stamp, out_if.timestamp);
                    n_errors++;
                end
                if (out_if.frame_type !== want.ftype) begin
                    $error("frame_type: expected %0d, got %0d", want.ftype, out_if.frame_type);
                    n_errors++;
                end
                if (out_if.frame_position !== want.position) begin
                    $error("frame_position: expected %0d, got %0d",
                           want.position, out_if.frame_position);
                    n_errors++;
                end
                if (out_if.frame_length !== want.length) begin
                    $error("frame_length: expected %0d, got %0d", want.length, out_if.frame_length);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        out_if.ready    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_stream();
        test_clean_units();
        test_back_to_back();
        test_noisy_stream();
        test_mixed_stream();

        // drain and settle
        in_if.valid <= 1'b0;
        while (pending_index_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hang guard
    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
